### sv/xad_pkg.sv
// Shared types, constants and coefficient tables for the XA ADPCM word decoder.
package xad_pkg;

  localparam int unsigned WORD_W    = 16;
  localparam int unsigned NIB_W     = 4;
  localparam int unsigned SHIFT_W   = 4;
  localparam int unsigned FILT_W    = 2;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned HIST_W    = 32;
  localparam int unsigned COEF_W    = 12;
  localparam int unsigned FRAC_BITS = 4;
  localparam int unsigned COEF_BITS = 10;
  localparam int unsigned CODES_PER_WORD = 4;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [HIST_W-1:0] hist_t;

  typedef enum logic [0:0] {
    REQ_DECODE       = 1'b0,
    REQ_CLEAR_DECODE = 1'b1
  } req_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  // History register file control.
  typedef struct packed {
    logic clear;
    logic wr_en;
  } hist_ctrl_t;

  // Coefficient of the newer history value, scaled by 1024.
  function automatic coef_t coef_newer(input logic [FILT_W-1:0] filt);
    coef_t k;
    case (filt)
      2'd0:    k = 12'sd0;
      2'd1:    k = 12'sd960;
      2'd2:    k = 12'sd1840;
      2'd3:    k = 12'sd1568;
      default: k = 12'sd0;
    endcase
    return k;
  endfunction

  // Coefficient of the older history value, scaled by 1024.
  function automatic coef_t coef_older(input logic [FILT_W-1:0] filt);
    coef_t k;
    case (filt)
      2'd0:    k = 12'sd0;
      2'd1:    k = 12'sd0;
      2'd2:    k = -12'sd832;
      2'd3:    k = -12'sd880;
      default: k = 12'sd0;
    endcase
    return k;
  endfunction

endpackage

### sv/xad_in_if.sv
// Input word channel: valid/ready handshake with the decode request payload.
interface xad_in_if
  import xad_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [WORD_W-1:0]   data_word;
  logic [SHIFT_W-1:0]  shift_amount;
  logic [FILT_W-1:0]   filter_select;
  logic                channel;

  modport source (
    output valid, req_type, data_word, shift_amount, filter_select, channel,
    input  ready
  );
  modport sink (
    input  valid, req_type, data_word, shift_amount, filter_select, channel,
    output ready
  );
endinterface

### sv/xad_out_if.sv
// Output sample channel: valid/ready handshake with the PCM sample payload.
interface xad_out_if
  import xad_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_of_word;

  modport source (
    output valid, sample, last_of_word,
    input  ready
  );
  modport sink (
    input  valid, sample, last_of_word,
    output ready
  );
endinterface

### sv/xa_adpcm_word_decoder_core.sv
// Top level of the XA ADPCM word decoder: sequencer, history and output register.
//
// Usage:
//   in_i  (sink)   one word per handshake: four 4-bit codes plus shift, filter
//                  number, channel and a request type that may clear all history.
//   out_o (source) four PCM samples per word, low nibble first; last_of_word
//                  marks the fourth.
// Datapath: a taken word loads the word registers; each sample is registered at the output.
// Throughput: one sample per cycle from a single shared step unit (two 12x32
//   products, a rounding add and saturation) when the receiver keeps up. The
//   step unit runs once per code, and each code needs the history left by the
//   one before.
// The next word is taken in the cycle the fourth sample is produced, so words
//   stream back to back.
// Reset: all channel histories clear to zero, no sample pending, ready high.
// Stall: while a sample waits on out_o, the sequencer holds; the pending
//   sample and its payload stay put until taken.
module xa_adpcm_word_decoder_core
  import xad_pkg::*;
#(
  parameter int unsigned CHANNELS = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  xad_in_if.sink    in_i,
  xad_out_if.source out_o
);

  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(CODES_PER_WORD);

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q;
  logic [WORD_W-1:0]    word_q;
  logic [SHIFT_W-1:0]   shift_q;
  logic [FILT_W-1:0]    filt_q;
  logic [CH_W-1:0]      ch_q;
  logic                 out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                 last_q;

  logic       accept;
  logic       step_en;
  logic       last_step;
  hist_ctrl_t hist_ctrl;
  hist_t      hist_newer;
  hist_t      hist_older;
  hist_t      hist_next;
  logic signed [SAMPLE_W-1:0] step_sample;
  logic [CH_W-1:0] in_ch_idx;

  // Channel index wraps onto the channels that exist.
  assign in_ch_idx = (CHANNELS > 1) ? CH_W'(in_i.channel) : '0;

  // Outputs of the sequencer: in the run state, step whenever the output slot is free or
  // being emptied; take the next word while idle or on the fourth step.
  always_comb begin
    step_en   = (state_q == ST_RUN) && (!out_valid_q || out_o.ready);
    last_step = step_en && (count_q == CNT_W'(CODES_PER_WORD - 1));
    in_i.ready = (state_q == ST_IDLE) || last_step;
    accept    = in_i.valid && in_i.ready;
    hist_ctrl.clear = accept && (in_i.req_type == REQ_CLEAR_DECODE);
    hist_ctrl.wr_en = step_en;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (last_step) state_d = accept ? ST_RUN : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        count_q <= '0;
      end else if (step_en) begin
        count_q <= count_q + 1'b1;
      end
      if (step_en) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Word fields: load on accept, advance one nibble per step.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q  <= in_i.data_word;
      shift_q <= in_i.shift_amount;
      filt_q  <= in_i.filter_select;
      ch_q    <= in_ch_idx;
    end else if (step_en) begin
      word_q <= word_q >> NIB_W;
    end
    if (step_en) begin
      sample_q <= step_sample;
      last_q   <= last_step;
    end
  end

  xad_history #(
    .CHANNELS (CHANNELS),
    .CH_W     (CH_W)
  ) u_history (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (hist_ctrl),
    .idx_i     (ch_q),
    .wr_data_i (hist_next),
    .newer_o   (hist_newer),
    .older_o   (hist_older)
  );

  xad_step_unit u_step (
    .nibble_i (word_q[NIB_W-1:0]),
    .shift_i  (shift_q),
    .filt_i   (filt_q),
    .newer_i  (hist_newer),
    .older_i  (hist_older),
    .hist_o   (hist_next),
    .sample_o (step_sample)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.sample       = sample_q;
  assign out_o.last_of_word = last_q;

endmodule

### sv/xad_step_unit.sv
// Shared decode step: scales one code, adds the filter prediction, saturates and clamps.
module xad_step_unit
  import xad_pkg::*;
(
  input  logic [NIB_W-1:0]           nibble_i,
  input  logic [SHIFT_W-1:0]         shift_i,
  input  logic [FILT_W-1:0]          filt_i,
  input  hist_t                      newer_i,
  input  hist_t                      older_i,
  output hist_t                      hist_o,
  output logic signed [SAMPLE_W-1:0] sample_o
);

  localparam int unsigned PROD_W = HIST_W + COEF_W;
  localparam int unsigned PRED_W = PROD_W + 1;
  localparam int unsigned NEG_W  = PRED_W + 1;
  localparam int unsigned CODE_W = WORD_W + FRAC_BITS;
  localparam int unsigned X_W    = NEG_W + 1;
  localparam int unsigned SH_W   = HIST_W - FRAC_BITS;

  logic signed [WORD_W-1:0] code_top;
  logic signed [WORD_W-1:0] code_sh;
  logic signed [CODE_W-1:0] code;
  coef_t                    k0;
  coef_t                    k1;
  logic signed [PROD_W-1:0] prod_n;
  logic signed [PROD_W-1:0] prod_o;
  logic signed [PRED_W-1:0] pred;
  logic signed [NEG_W-1:0]  neg_q;
  logic signed [X_W-1:0]    x_full;
  logic signed [SH_W-1:0]   x_int;

  // Sign-extend the code from the top nibble, shift, add fraction bits.
  assign code_top = {nibble_i, {(WORD_W-NIB_W){1'b0}}};
  assign code_sh  = code_top >>> shift_i;
  assign code     = {code_sh, {FRAC_BITS{1'b0}}};

  assign k0     = coef_newer(filt_i);
  assign k1     = coef_older(filt_i);
  assign prod_n = PROD_W'(k0) * PROD_W'(newer_i);
  assign prod_o = PROD_W'(k1) * PROD_W'(older_i);
  assign pred   = PRED_W'(prod_n) + PRED_W'(prod_o);

  // Round the prediction toward +inf: code - floor(-pred / 1024).
  assign neg_q  = (-NEG_W'(pred)) >>> COEF_BITS;
  assign x_full = X_W'(code) - X_W'(neg_q);

  always_comb begin
    if (x_full > X_W'(hist_t'({1'b0, {(HIST_W-1){1'b1}}}))) begin
      hist_o = {1'b0, {(HIST_W-1){1'b1}}};
    end else if (x_full < X_W'(hist_t'({1'b1, {(HIST_W-1){1'b0}}}))) begin
      hist_o = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      hist_o = x_full[HIST_W-1:0];
    end
  end

  assign x_int = SH_W'(hist_o >>> FRAC_BITS);

  always_comb begin
    if (x_int > SH_W'($signed({1'b0, {(SAMPLE_W-1){1'b1}}}))) begin
      sample_o = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (x_int < SH_W'($signed({1'b1, {(SAMPLE_W-1){1'b0}}}))) begin
      sample_o = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sample_o = x_int[SAMPLE_W-1:0];
    end
  end

endmodule

### sv/xad_history.sv
// Per-channel prediction history registers with a clear-all and a shift-in write.
module xad_history
  import xad_pkg::*;
#(
  parameter int unsigned CHANNELS = 2,
  parameter int unsigned CH_W     = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hist_ctrl_t      ctrl_i,
  input  logic [CH_W-1:0] idx_i,
  input  hist_t           wr_data_i,
  output hist_t           newer_o,
  output hist_t           older_o
);

  hist_t newer_q [CHANNELS];
  hist_t older_q [CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        newer_q[i] <= '0;
        older_q[i] <= '0;
      end
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < CHANNELS; i++) begin
        newer_q[i] <= '0;
        older_q[i] <= '0;
      end
    end else if (ctrl_i.wr_en) begin
      older_q[idx_i] <= newer_q[idx_i];
      newer_q[idx_i] <= wr_data_i;
    end
  end

  assign newer_o = newer_q[idx_i];
  assign older_o = older_q[idx_i];

endmodule

### sv/xad_checker.sv
// Port-level checks for the XA ADPCM word decoder, bound to the top level.
module xad_checker
  import xad_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic signed [SAMPLE_W-1:0] sample_i,
  input logic                       last_of_word_i
);

  // Hold a stalled sample.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sample_i)
                                    && $stable(last_of_word_i))
    else $error("stalled sample changed");

  // Stay busy right after taking a word.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready right after accepting a word");

  // Keep samples of a word flowing once one is taken mid-word.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_of_word_i |=> out_valid_i)
    else $error("gap inside a word");

  // Open a burst only with the first sample of a word.
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !last_of_word_i)
    else $error("burst opened with last sample");

endmodule

bind xa_adpcm_word_decoder_core xad_checker u_xad_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .sample_i       (out_o.sample),
  .last_of_word_i (out_o.last_of_word)
);

### dv/tb_xa_adpcm_word_decoder_core.sv
// Self-checking testbench for the XA ADPCM word decoder core with a built-in decode model.
`timescale 1ns / 100ps

module tb_xa_adpcm_word_decoder_core;
  import xad_pkg::*;

  localparam int unsigned CHANNELS    = 2;
  localparam int unsigned MAX_WAIT    = 19;   // longest source gap / sink stall
  localparam int unsigned QUIET_LIMIT = 1000; // cycles without any handshake
  localparam int unsigned DRAIN       = 10;   // cycles to watch after the last sample
  localparam int unsigned RAND_WORDS  = 176;

  // One decode request plus the idle gap the source inserts before it.
  typedef struct {
    req_e                kind;
    logic [WORD_W-1:0]   word;
    logic [SHIFT_W-1:0]  shift;
    logic [FILT_W-1:0]   filt;
    logic                chan;
    int unsigned         gap;
  } dec_req_t;

  // One expected PCM sample.
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } pcm_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  xad_in_if  in_if ();
  xad_out_if out_if ();

  xa_adpcm_word_decoder_core #(
    .CHANNELS(CHANNELS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #1 clk_i = ~clk_i;

  dec_req_t    word_queue[$];   // words not yet offered to the block
  pcm_t        pcm_expected[$]; // samples predicted but not yet seen
  dec_req_t    cur_req;         // word currently offered on in_if
  bit          feed_on = 1'b0;

  // Private copy of the per-channel prediction history.
  hist_t       hist_newer[CHANNELS];
  hist_t       hist_older[CHANNELS];

  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned quiet;
  int unsigned err_count   = 0;
  int unsigned words_in    = 0;
  int unsigned clears_in   = 0;
  int unsigned samples_out = 0;
  int unsigned clamp_hits  = 0;
  int unsigned filt_seen[4];

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input longint got, input longint exp);
    err_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d (sample #%0d)",
             $realtime, what, got, exp, samples_out);
  endtask

  // Decode one accepted word against the private history and queue its four samples.
  function automatic void predict_pcm(input dec_req_t r);
    int unsigned ch;
    int          k;
    longint      k_new, k_old, nib, code, acc, x, s;
    pcm_t        e;
    ch = r.chan % CHANNELS;
    // Restart wipes every channel, not only the selected one.
    if (r.kind == REQ_CLEAR_DECODE) begin
      for (int i = 0; i < CHANNELS; i++) begin
        hist_newer[i] = '0;
        hist_older[i] = '0;
      end
    end
    case (r.filt)
      2'd1:    begin k_new = 960;  k_old = 0;    end
      2'd2:    begin k_new = 1840; k_old = -832; end
      2'd3:    begin k_new = 1568; k_old = -880; end
      default: begin k_new = 0;    k_old = 0;    end
    endcase
    for (k = 0; k < CODES_PER_WORD; k++) begin
      nib  = longint'($signed(r.word[NIB_W*k +: NIB_W]));
      // Code sits in the top nibble of 16 bits, arithmetic shift, then 4 fraction bits.
      code = ((nib * 4096) >>> r.shift) * 16;
      acc  = k_new * longint'(hist_newer[ch]) + k_old * longint'(hist_older[ch]);
      // Prediction rounds toward +inf: subtract the floor of the negated sum.
      x    = code - ((-acc) >>> COEF_BITS);
      if (x > 64'sd2147483647)  x = 64'sd2147483647;
      if (x < -64'sd2147483648) x = -64'sd2147483648;
      hist_older[ch] = hist_newer[ch];
      hist_newer[ch] = hist_t'(x);
      s = x >>> FRAC_BITS;
      if (s > 32767) begin
        s = 32767;
        clamp_hits++;
      end else if (s < -32768) begin
        s = -32768;
        clamp_hits++;
      end
      e.sample = SAMPLE_W'(s);
      e.last   = (k == CODES_PER_WORD - 1);
      pcm_expected.push_back(e);
    end
  endfunction

  // Append one word to the stimulus; a calm word gets no gap in front of it.
  task automatic queue_word(input req_e kind, input logic [WORD_W-1:0] w,
                            input int unsigned sh, input int unsigned fl,
                            input int unsigned chn, input bit calm);
    dec_req_t r;
    r.kind  = kind;
    r.word  = w;
    r.shift = SHIFT_W'(sh);
    r.filt  = FILT_W'(fl);
    r.chan  = chn[0];
    r.gap   = calm ? 0 : $urandom_range(0, MAX_WAIT);
    word_queue.push_back(r);
  endtask

  // Source side: offer words from the queue, predict on every handshake.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      gap_left    <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_pcm(cur_req);
        words_in++;
        filt_seen[cur_req.filt]++;
        if (cur_req.kind == REQ_CLEAR_DECODE) clears_in++;
      end
      // The slot is free when nothing is offered or the offer was just taken.
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          in_if.valid <= 1'b0;
          gap_left    <= gap_left - 1;
        end else if (feed_on && word_queue.size() != 0) begin
          cur_req = word_queue.pop_front();
          in_if.valid         <= 1'b1;
          in_if.req_type      <= cur_req.kind;
          in_if.data_word     <= cur_req.word;
          in_if.shift_amount  <= cur_req.shift;
          in_if.filter_select <= cur_req.filt;
          in_if.channel       <= cur_req.chan;
          // Arm the gap that goes in front of the next word.
          gap_left <= (word_queue.size() != 0) ? word_queue[0].gap : 0;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Sink side: check each taken sample, then stall a random number of cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned stall;
    pcm_t        e;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pcm_expected.size() == 0) begin
          report_mismatch("unexpected sample", out_if.sample, 0);
        end else begin
          e = pcm_expected.pop_front();
          if (out_if.sample !== e.sample)
            report_mismatch("sample", out_if.sample, e.sample);
          if (out_if.last_of_word !== e.last)
            report_mismatch("last_of_word", out_if.last_of_word, e.last);
        end
        samples_out++;
        // Every third stretch of 48 samples runs with the sink always ready.
        stall = (((samples_out / 48) % 3) == 2) ? 0 : $urandom_range(0, MAX_WAIT);
        out_if.ready <= (stall == 0);
        stall_left   <= stall;
      end else if (!out_if.ready) begin
        if (stall_left <= 1) out_if.ready <= 1'b1;
        stall_left <= (stall_left == 0) ? 0 : stall_left - 1;
      end
    end
  end

  // Watchdog: end the run when no word and no sample moves for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet <= 0;
    end else if (rst_ni) begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: %0d idle cycles, %0d words unsent, %0d samples outstanding",
                 quiet, word_queue.size(), pcm_expected.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n_unit, len, sh, fl, chn;
    bit          calm, noisy;
    req_e        kind;

    // Hold every input at a known value from time zero.
    in_if.valid         = 1'b0;
    in_if.req_type      = REQ_DECODE;
    in_if.data_word     = '0;
    in_if.shift_amount  = '0;
    in_if.filter_select = '0;
    in_if.channel       = 1'b0;
    out_if.ready        = 1'b0;
    quiet               = 0;
    for (int i = 0; i < CHANNELS; i++) begin
      hist_newer[i] = '0;
      hist_older[i] = '0;
    end
    for (int i = 0; i < 4; i++) filt_seen[i] = 0;

    // Directed words: nibble extremes, every filter, large shifts, clamping, restart.
    queue_word(REQ_CLEAR_DECODE, 16'h0000, 0, 0, 0, 1'b0);
    queue_word(REQ_DECODE, 16'h8787, 0, 0, 0, 1'b0);
    queue_word(REQ_DECODE, 16'h7878, 0, 1, 1, 1'b0);
    queue_word(REQ_DECODE, 16'hFFFF, 15, 0, 0, 1'b0);
    queue_word(REQ_DECODE, 16'h8888, 12, 0, 1, 1'b0);
    queue_word(REQ_DECODE, 16'h8888, 13, 1, 1, 1'b0);
    queue_word(REQ_DECODE, 16'h7777, 14, 0, 0, 1'b0);
    queue_word(REQ_DECODE, 16'h8888, 15, 0, 0, 1'b0);
    // Drive the channel 0 history up until the output clamps high, then swing low.
    repeat (6) queue_word(REQ_DECODE, 16'h7777, 0, 2, 0, 1'b1);
    repeat (4) queue_word(REQ_DECODE, 16'h8888, 0, 2, 0, 1'b0);
    repeat (3) queue_word(REQ_DECODE, 16'h9A5C, 3, 3, 1, 1'b0);
    // Restart on channel 1 must also wipe the channel 0 history.
    queue_word(REQ_CLEAR_DECODE, 16'h0000, 0, 2, 1, 1'b0);
    queue_word(REQ_DECODE, 16'h0000, 0, 2, 0, 1'b0);
    queue_word(REQ_DECODE, 16'h1234, 4, 3, 1, 1'b0);

    // Random part: mostly sound groups of up to seven words sharing one header,
    // some groups with a fresh header on every word, an occasional restart.
    n_unit = 0;
    while (word_queue.size() < 24 + RAND_WORDS) begin
      len   = $urandom_range(1, 7);
      calm  = (n_unit % 4) == 3;
      noisy = $urandom_range(0, 5) == 0;
      sh    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 12);
      fl    = $urandom_range(0, 3);
      chn   = $urandom_range(0, 1);
      for (int w = 0; w < len; w++) begin
        if (noisy) begin
          sh  = $urandom_range(0, 15);
          fl  = $urandom_range(0, 3);
          chn = $urandom_range(0, 1);
        end
        kind = (w == 0 && $urandom_range(0, 11) == 0) ? REQ_CLEAR_DECODE : REQ_DECODE;
        queue_word(kind, WORD_W'($urandom_range(0, 16'hFFFF)), sh, fl, chn, calm);
      end
      n_unit++;
    end

    // Release reset and start feeding.
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni  = 1'b1;
    feed_on = 1'b1;

    // Wait for the last word to be taken, then for its samples.
    do @(negedge clk_i); while (word_queue.size() != 0 || in_if.valid);
    do @(negedge clk_i); while (pcm_expected.size() != 0);
    // Watch a few more cycles for stray samples.
    repeat (DRAIN) @(negedge clk_i);

    $display("Decoded %0d words (%0d with restart) into %0d samples, %0d clamped.",
             words_in, clears_in, samples_out, clamp_hits);
    $display("Words per filter: %0d / %0d / %0d / %0d; mismatches: %0d.",
             filt_seen[0], filt_seen[1], filt_seen[2], filt_seen[3], err_count);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
